FILE: hdl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// shared types, constants and header decode for the command frame receiver
// ----------------------------------------------------------------------------
package cfr_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int GAIN_FIRST  = 4;
    localparam int GAIN_COUNT  = 9;
    localparam int HDR_BYTES   = GAIN_FIRST + 2 * GAIN_COUNT;

    // frame queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // header byte values
    localparam logic [7:0] MARK_START   = 8'h8A;
    localparam logic [7:0] MARK_SECOND  = 8'h8B;
    localparam logic [7:0] MARK_THIRD   = 8'h1C;
    localparam logic [7:0] CODE_CAL     = 8'hAA;
    localparam logic [7:0] CODE_CAL_SUB = 8'hA3;
    localparam logic [7:0] CODE_READ    = 8'hAD;
    localparam logic [7:0] CODE_WRITE   = 8'hAE;

    // command codes
    localparam logic [1:0] CMD_INVALID = 2'd0;
    localparam logic [1:0] CMD_CAL     = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_WRITE   = 2'd3;

    typedef logic [7:0] t_byte;

    // leading bytes of a frame, the only ones that reach the result
    typedef t_byte [HDR_BYTES-1:0] t_frame;

    typedef struct packed {
        logic [1:0]                   command;
        logic [GAIN_COUNT-1:0][15:0]  gain;
    } t_result;

    typedef struct packed {
        logic   valid;
        t_frame data;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_result decode_frame(input t_frame f);
        t_result r;
        logic    head;
        head = (f[0] == MARK_START) && (f[1] == MARK_SECOND) && (f[2] == MARK_THIRD);
        if (head && f[3] == CODE_CAL && f[4] == CODE_CAL_SUB) begin
            r.command = CMD_CAL;
        end else if (head && f[3] == CODE_READ) begin
            r.command = CMD_READ;
        end else if (head && f[3] == CODE_WRITE) begin
            r.command = CMD_WRITE;
        end else begin
            r.command = CMD_INVALID;
        end
        for (int k = 0; k < GAIN_COUNT; k++) begin
            if (r.command == CMD_WRITE) begin
                r.gain[k] = {f[GAIN_FIRST + 2 * k], f[GAIN_FIRST + 2 * k + 1]};
            end else begin
                r.gain[k] = 16'd0;
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/cfr_front.sv
// ----------------------------------------------------------------------------
// cfr_front
// byte intake: start marker hunt, position count and frame capture
// ----------------------------------------------------------------------------
module cfr_front
    import cfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    input  t_byte   i_rx_byte,
    output logic    o_rx_ready,
    input  t_q_stat i_q_stat,
    output t_push   o_push
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic             r_capturing, n_capturing;
    logic [POS_W-1:0] r_pos, n_pos;
    t_frame           r_bytes;
    t_frame           w_merged;
    logic             w_accept;
    logic             w_take;
    logic             w_last;

    // only the frame-completing byte needs a queue slot
    assign o_rx_ready = !(r_capturing && (r_pos == LAST_POS) && i_q_stat.full);
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_take     = w_accept && (r_capturing || (i_rx_byte == MARK_START));
    assign w_last     = r_pos == LAST_POS;

    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            w_merged[i] = (r_pos == POS_W'(i)) ? i_rx_byte : r_bytes[i];
        end
    end

    always_comb begin
        n_capturing = r_capturing;
        n_pos       = r_pos;
        if (w_take) begin
            if (w_last) begin
                n_capturing = 1'b0;
                n_pos       = '0;
            end else begin
                n_capturing = 1'b1;
                n_pos       = r_pos + POS_W'(1);
            end
        end
    end

    assign o_push.valid = w_take && w_last;
    assign o_push.data  = w_merged;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_capturing <= n_capturing;
            r_pos       <= n_pos;
        end
    end

    // bytes past the gain words are counted but not kept
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_bytes <= w_merged;
        end
    end

endmodule

FILE: hdl/cfr_queue.sv
// ----------------------------------------------------------------------------
// cfr_queue
// short frame queue between intake and result stage
// ----------------------------------------------------------------------------
module cfr_queue
    import cfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_frame  o_head,
    output t_q_stat o_stat
);

    t_frame              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_stat.full  = r_count == QCNT_W'(Q_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push.valid ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push.valid) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

FILE: hdl/cfr_back.sv
// ----------------------------------------------------------------------------
// cfr_back
// header decode and registered result output
// ----------------------------------------------------------------------------
module cfr_back
    import cfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_frame  i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_pop    = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= decode_frame(i_head);
        end
    end

endmodule

FILE: hdl/command_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// command_frame_receiver_top
// assembles command frames from received serial bytes
// ----------------------------------------------------------------------------
// usage:
//   rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one byte per
//   transaction. bytes are dropped until 0x8a arrives; that byte and the
//   following ones fill a frame of FRAME_BYTES bytes. a further 0x8a inside
//   a frame is plain data.
//   cmd channel (o_cmd_valid / i_cmd_ready) gives one transaction per
//   finished frame: the command code and nine big-endian gain words in
//   thousandths. gains read zero unless the command is a gain write.
// timing:
//   one byte per cycle sustained while o_rx_ready is high. a finished frame
//   is written into the frame queue and then decoded into the output
//   register of the result stage.
// reset and stall:
//   reset drops any partial frame, empties the queue and clears o_cmd_valid.
//   a stalled result holds in its output register while intake goes on; a
//   two-deep frame queue absorbs further frames, and o_rx_ready drops only
//   on a frame-completing byte while that queue is full.
// ----------------------------------------------------------------------------
module command_frame_receiver_top
    import cfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // rx byte channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // command result channel
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output logic [1:0]  o_command,
    output logic [15:0] o_roll_prop,
    output logic [15:0] o_roll_integ,
    output logic [15:0] o_roll_deriv,
    output logic [15:0] o_pitch_prop,
    output logic [15:0] o_pitch_integ,
    output logic [15:0] o_pitch_deriv,
    output logic [15:0] o_yaw_prop,
    output logic [15:0] o_yaw_integ,
    output logic [15:0] o_yaw_deriv
);

    t_push   w_push;     // finished frame from intake
    t_q_stat w_q_stat;   // queue occupancy seen by both sides
    t_frame  w_head;     // oldest queued frame
    logic    w_pop;
    t_result w_result;

    // front: marker hunt and capture
    cfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_rx_ready),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push)
    );

    // decouples intake from a stalled consumer
    cfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // back: decode and output register
    cfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_cmd_valid),
        .i_ready  (i_cmd_ready),
        .o_result (w_result)
    );

    // gain order follows the frame layout
    assign o_command     = w_result.command;
    assign o_roll_prop   = w_result.gain[0];
    assign o_roll_integ  = w_result.gain[1];
    assign o_roll_deriv  = w_result.gain[2];
    assign o_pitch_prop  = w_result.gain[3];
    assign o_pitch_integ = w_result.gain[4];
    assign o_pitch_deriv = w_result.gain[5];
    assign o_yaw_prop    = w_result.gain[6];
    assign o_yaw_integ   = w_result.gain[7];
    assign o_yaw_deriv   = w_result.gain[8];

endmodule

FILE: hdl/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// port-level checks for the command frame receiver
// ----------------------------------------------------------------------------
module cfr_checker
    import cfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_ready,
    input logic        o_cmd_valid,
    input logic        i_cmd_ready,
    input logic [1:0]  o_command,
    input logic [15:0] o_roll_prop,
    input logic [15:0] o_roll_integ,
    input logic [15:0] o_roll_deriv,
    input logic [15:0] o_pitch_prop,
    input logic [15:0] o_pitch_integ,
    input logic [15:0] o_pitch_deriv,
    input logic [15:0] o_yaw_prop,
    input logic [15:0] o_yaw_integ,
    input logic [15:0] o_yaw_deriv
);

    logic w_gains_zero;

    assign w_gains_zero = (o_roll_prop == 16'd0) && (o_roll_integ == 16'd0) &&
                          (o_roll_deriv == 16'd0) && (o_pitch_prop == 16'd0) &&
                          (o_pitch_integ == 16'd0) && (o_pitch_deriv == 16'd0) &&
                          (o_yaw_prop == 16'd0) && (o_yaw_integ == 16'd0) &&
                          (o_yaw_deriv == 16'd0);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && !i_cmd_ready |=>
            o_cmd_valid && $stable(o_command) && $stable(o_roll_prop) &&
            $stable(o_yaw_deriv))
        else $error("stalled command result changed");

    // gains only on a gain write
    a_gain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && (o_command != CMD_WRITE) |-> w_gains_zero)
        else $error("nonzero gains on a non-write command");

    // a fresh result is preceded by a byte transaction
    a_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd_valid) |-> $past(i_rx_valid && o_rx_ready, 2))
        else $error("result appeared without a completing byte");

    // nothing pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_cmd_valid)
        else $error("result valid after reset");

endmodule

bind command_frame_receiver_top cfr_checker u_cfr_checker (.*);
